[src/assert_macros.svh]
// Assertion macros used by the octave cell of the noise pipeline.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked assertion, switched off while reset is low.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
// Clocked assertion that also holds through reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[src/pnos_pkg.sv]
// Types, constants and arithmetic helpers for the 3D octave noise block.
`timescale 1ns / 1ps
package pnos_pkg;

    localparam int DEFAULT_COORD_BITS  = 10;
    localparam int DEFAULT_MAX_OCTAVES = 8;

    localparam int FRAC_BITS   = 16;
    localparam int SAMPLE_W    = 24;
    localparam int CELL_W      = SAMPLE_W - FRAC_BITS;
    localparam int FREQ_W      = 24;
    localparam int AMP_W       = 24;
    localparam int PERS_W      = 16;
    localparam int CNT_W       = 4;
    localparam int NOISE_W     = 25;
    localparam int SUM_W       = 34;
    localparam int TERM_W      = 30;
    localparam int DIST_W      = FRAC_BITS + 2;
    localparam int LERP_W      = 21;
    localparam int FADE_W      = FRAC_BITS + 1;
    localparam int P16_W       = 20;
    localparam int GRAD_W      = 4;
    localparam int CELL_STAGES = 8;
    localparam int CORNERS     = 8;
    localparam int AXES        = 3;

    localparam logic [FRAC_BITS-1:0] FRAC_MASK = '1;
    localparam logic [DIST_W-1:0]    Q_ONE     = DIST_W'(1) << FRAC_BITS;

    localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'(16777215);
    localparam logic signed [SUM_W-1:0] OUT_MIN = -SUM_W'(16777216);

    localparam logic [FREQ_W-1:0] RST_BASE_FREQ = FREQ_W'(4096);
    localparam logic [AMP_W-1:0]  RST_START_AMP = AMP_W'(65536);
    localparam logic [PERS_W-1:0] RST_PERSIST   = PERS_W'(32768);
    localparam logic [CNT_W-1:0]  RST_OCT_COUNT = CNT_W'(4);

    // Only the low byte of each hash prime reaches the 8-bit result.
    localparam logic [31:0] HASH_PX = 32'd73856093;
    localparam logic [31:0] HASH_PY = 32'd19349663;
    localparam logic [31:0] HASH_PZ = 32'd83492791;

    localparam int GRAD_COUNT = 12;
    // floor(h/12) = (h*171) >> 11 for every byte h
    localparam logic [7:0] DIV12_MUL   = 8'd171;
    localparam int         DIV12_SHIFT = 11;

    localparam logic signed [1:0] GRAD_X [GRAD_COUNT] =
        '{2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd1, -2'sd1,
          2'sd0, 2'sd0, 2'sd0, 2'sd0};
    localparam logic signed [1:0] GRAD_Y [GRAD_COUNT] =
        '{2'sd1, 2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0,
          2'sd1, -2'sd1, 2'sd1, -2'sd1};
    localparam logic signed [1:0] GRAD_Z [GRAD_COUNT] =
        '{2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd1, 2'sd1, -2'sd1, -2'sd1,
          2'sd1, 2'sd1, -2'sd1, -2'sd1};

    typedef enum logic [1:0] {
        REG_BASE_FREQ = 2'd0,
        REG_START_AMP = 2'd1,
        REG_PERSIST   = 2'd2,
        REG_OCT_COUNT = 2'd3
    } pnos_reg_e;

    typedef struct packed {
        logic [FREQ_W-1:0] base_frequency;
        logic [AMP_W-1:0]  start_amplitude;
        logic [PERS_W-1:0] persistence;
        logic [CNT_W-1:0]  octave_count;
    } pnos_cfg_t;

    // What travels from one octave cell to the next.
    typedef struct packed {
        logic [AXES-1:0][SAMPLE_W-1:0] sample;
        logic [AMP_W-1:0]              amp;
        logic signed [SUM_W-1:0]       sum;
    } pnos_carry_t;

    function automatic logic [GRAD_W-1:0] grad_index(input logic [CELL_W-1:0] cx,
                                                     input logic [CELL_W-1:0] cy,
                                                     input logic [CELL_W-1:0] cz);
        logic [CELL_W-1:0] h;
        logic [18:0]       q;
        logic [CELL_W-1:0] r;
        h = (cx * HASH_PX[7:0]) ^ (cy * HASH_PY[7:0]) ^ (cz * HASH_PZ[7:0]);
        q = (19'(h) * 19'(DIV12_MUL)) >> DIV12_SHIFT;
        r = h - CELL_W'(q[4:0] * 8'(GRAD_COUNT));
        return r[GRAD_W-1:0];
    endfunction

    function automatic logic signed [LERP_W-1:0] grad_term(input logic signed [1:0] c,
                                                           input logic signed [DIST_W-1:0] d);
        logic signed [LERP_W-1:0] dx;
        dx = LERP_W'(d);
        if (c == 2'sd1)
            return dx;
        else if (c == -2'sd1)
            return -dx;
        else
            return '0;
    endfunction

    function automatic logic signed [LERP_W-1:0] corner_dot(input logic [GRAD_W-1:0] g,
                                                            input logic signed [DIST_W-1:0] dx,
                                                            input logic signed [DIST_W-1:0] dy,
                                                            input logic signed [DIST_W-1:0] dz);
        if (int'(g) >= GRAD_COUNT)
            return '0;
        return grad_term(GRAD_X[g], dx) + grad_term(GRAD_Y[g], dy) + grad_term(GRAD_Z[g], dz);
    endfunction

    // a + (b-a)*t / 2^16, quotient rounded toward zero
    function automatic logic signed [LERP_W-1:0] lerp_q16(input logic signed [LERP_W-1:0] a,
                                                          input logic signed [LERP_W-1:0] b,
                                                          input logic [FADE_W-1:0] t);
        logic signed [LERP_W:0]          diff;
        logic signed [LERP_W+FADE_W+1:0] prod;
        logic signed [LERP_W+FADE_W+1:0] adj;
        diff = (LERP_W+1)'(b) - (LERP_W+1)'(a);
        prod = (LERP_W+FADE_W+2)'(diff) * (LERP_W+FADE_W+2)'($signed({1'b0, t}));
        adj  = (prod < 0) ? prod + (LERP_W+FADE_W+2)'(FRAC_MASK) : prod;
        return a + LERP_W'(adj >>> FRAC_BITS);
    endfunction

endpackage

[src/pnos_scale.sv]
// Entry stage: scales the voxel coordinate by the base frequency.
`timescale 1ns / 1ps
module pnos_scale
    import pnos_pkg::*;
#(
    parameter int COORD_BITS = DEFAULT_COORD_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  pnos_cfg_t             cfg,
    input  logic                  in_valid,
    input  logic [COORD_BITS-1:0] coord_x,
    input  logic [COORD_BITS-1:0] coord_y,
    input  logic [COORD_BITS-1:0] coord_z,
    output logic                  out_valid,
    output pnos_carry_t           out_carry
);

    localparam int PROD_W = COORD_BITS + FREQ_W;

    logic        valid_reg;
    pnos_carry_t carry_reg;
    pnos_carry_t carry_next;
    logic [PROD_W-1:0] px, py, pz;

    // Only the low 8 integer bits and the fraction are ever used.
    always_comb
    begin
        px = PROD_W'(coord_x) * PROD_W'(cfg.base_frequency);
        py = PROD_W'(coord_y) * PROD_W'(cfg.base_frequency);
        pz = PROD_W'(coord_z) * PROD_W'(cfg.base_frequency);
        carry_next.sample[0] = px[SAMPLE_W-1:0];
        carry_next.sample[1] = py[SAMPLE_W-1:0];
        carry_next.sample[2] = pz[SAMPLE_W-1:0];
        carry_next.amp       = cfg.start_amplitude;
        carry_next.sum       = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            carry_reg <= carry_next;
    end

    assign out_valid = valid_reg;
    assign out_carry = carry_reg;

endmodule

[src/pnos_cell.sv]
// One octave cell: gradient noise of one octave, weighted and added to the running sum.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pnos_cell
    import pnos_pkg::*;
#(
    parameter int OCT_INDEX = 0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  pnos_cfg_t   cfg,
    input  logic        in_valid,
    input  pnos_carry_t in_carry,
    output logic        out_valid,
    output pnos_carry_t out_carry
);

    logic [CELL_STAGES-1:0] valid_reg;
    pnos_carry_t            carry_reg [CELL_STAGES];
    pnos_carry_t            carry_next;

    // stage 1
    logic [FRAC_BITS-1:0]   t1_reg    [AXES];
    logic [2*FRAC_BITS-1:0] tt1_reg   [AXES];
    logic [GRAD_W-1:0]      grad1_reg [CORNERS];
    // stage 2
    logic [FRAC_BITS-1:0]     t3_2_reg  [AXES];
    logic [P16_W-1:0]         p16_2_reg [AXES];
    logic signed [LERP_W-1:0] dot2_reg  [CORNERS];
    // stage 3
    logic [FADE_W-1:0]        fade3_reg [AXES];
    logic signed [LERP_W-1:0] dot3_reg  [CORNERS];
    // stage 4
    logic signed [LERP_W-1:0] lx4_reg [4];
    logic [FADE_W-1:0]        fy4_reg, fz4_reg;
    // stage 5
    logic signed [LERP_W-1:0] ly5_reg [2];
    logic [FADE_W-1:0]        fz5_reg;
    // stage 6
    logic signed [LERP_W-1:0] nv6_reg;
    // stage 7
    logic signed [TERM_W-1:0] term7_reg;
    logic [AMP_W-1:0]         amp7_reg;

    logic active;
    assign active = (int'(cfg.octave_count) > OCT_INDEX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (advance)
            valid_reg <= {valid_reg[CELL_STAGES-2:0], in_valid};
    end

    // stage 8 takes the accumulated sum and the doubled sample
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            carry_reg[0] <= in_carry;
            for (int s = 1; s < CELL_STAGES - 1; s++)
                carry_reg[s] <= carry_reg[s-1];
            carry_reg[CELL_STAGES-1] <= carry_next;
        end
    end

    // stage 1: split sample, square fraction, hash the corners
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < AXES; k++)
            begin
                t1_reg[k]  <= in_carry.sample[k][FRAC_BITS-1:0];
                tt1_reg[k] <= (2*FRAC_BITS)'(in_carry.sample[k][FRAC_BITS-1:0])
                              * (2*FRAC_BITS)'(in_carry.sample[k][FRAC_BITS-1:0]);
            end
            for (int i = 0; i < CORNERS; i++)
            begin
                grad1_reg[i] <= grad_index(
                    in_carry.sample[0][SAMPLE_W-1:FRAC_BITS] + CELL_W'(i[2]),
                    in_carry.sample[1][SAMPLE_W-1:FRAC_BITS] + CELL_W'(i[1]),
                    in_carry.sample[2][SAMPLE_W-1:FRAC_BITS] + CELL_W'(i[0]));
            end
        end
    end

    // stage 2: cube and fade polynomial, corner dot products
    logic [3*FRAC_BITS-1:0] t3_full [AXES];
    logic [36:0]            p_full  [AXES];
    logic signed [DIST_W-1:0] dnear [AXES];
    logic signed [DIST_W-1:0] dfar  [AXES];

    always_comb
    begin
        for (int k = 0; k < AXES; k++)
        begin
            t3_full[k] = (3*FRAC_BITS)'(tt1_reg[k]) * (3*FRAC_BITS)'(t1_reg[k]);
            p_full[k]  = 37'(tt1_reg[k]) * 37'd6 + (37'd10 << (2*FRAC_BITS))
                         - ((37'(t1_reg[k]) * 37'd15) << FRAC_BITS);
            dnear[k]   = $signed(DIST_W'(t1_reg[k]));
            dfar[k]    = $signed(DIST_W'(t1_reg[k]) - Q_ONE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < AXES; k++)
            begin
                t3_2_reg[k]  <= t3_full[k][3*FRAC_BITS-1:2*FRAC_BITS];
                p16_2_reg[k] <= p_full[k][FRAC_BITS+P16_W-1:FRAC_BITS];
            end
            for (int i = 0; i < CORNERS; i++)
            begin
                dot2_reg[i] <= corner_dot(grad1_reg[i],
                                          i[2] ? dfar[0] : dnear[0],
                                          i[1] ? dfar[1] : dnear[1],
                                          i[0] ? dfar[2] : dnear[2]);
            end
        end
    end

    // stage 3: fade = t^3 * p
    logic [FRAC_BITS+P16_W-1:0] fade_full [AXES];

    always_comb
    begin
        for (int k = 0; k < AXES; k++)
            fade_full[k] = (FRAC_BITS+P16_W)'(t3_2_reg[k]) * (FRAC_BITS+P16_W)'(p16_2_reg[k]);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < AXES; k++)
                fade3_reg[k] <= fade_full[k][FRAC_BITS+FADE_W-1:FRAC_BITS];
            dot3_reg <= dot2_reg;
        end
    end

    // stages 4 to 6: blend along x, then y, then z
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int j = 0; j < 4; j++)
                lx4_reg[j] <= lerp_q16(dot3_reg[j], dot3_reg[4+j], fade3_reg[0]);
            fy4_reg <= fade3_reg[1];
            fz4_reg <= fade3_reg[2];
            for (int c = 0; c < 2; c++)
                ly5_reg[c] <= lerp_q16(lx4_reg[c], lx4_reg[2+c], fy4_reg);
            fz5_reg <= fz4_reg;
            nv6_reg <= lerp_q16(ly5_reg[0], ly5_reg[1], fz5_reg);
        end
    end

    // stage 7: weight by amplitude, next amplitude
    localparam int WPROD_W = LERP_W + AMP_W + 1;
    logic signed [WPROD_W-1:0] wprod;
    logic signed [WPROD_W-1:0] wadj;
    logic [AMP_W+PERS_W-1:0]   amp_prod;

    always_comb
    begin
        wprod    = WPROD_W'(nv6_reg) * WPROD_W'($signed({1'b0, carry_reg[5].amp}));
        wadj     = (wprod < 0) ? wprod + WPROD_W'(FRAC_MASK) : wprod;
        amp_prod = (AMP_W+PERS_W)'(carry_reg[5].amp) * (AMP_W+PERS_W)'(cfg.persistence);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            term7_reg <= TERM_W'(wadj >>> FRAC_BITS);
            amp7_reg  <= amp_prod[AMP_W+PERS_W-1:PERS_W];
        end
    end

    // stage 8: accumulate and hand the next octave its doubled sample
    always_comb
    begin
        for (int k = 0; k < AXES; k++)
            carry_next.sample[k] = {carry_reg[6].sample[k][SAMPLE_W-2:0], 1'b0};
        carry_next.amp = amp7_reg;
        carry_next.sum = active ? carry_reg[6].sum + SUM_W'(term7_reg) : carry_reg[6].sum;
    end

    assign out_valid = valid_reg[CELL_STAGES-1];
    assign out_carry = carry_reg[CELL_STAGES-1];

    `ASSERT_CLK(a_stall_holds_valid, clk, rst_n, !advance |=> $stable(valid_reg))
    `ASSERT_CLK(a_valid_shifts, clk, rst_n, advance |=> valid_reg[1] == $past(valid_reg[0]))
    `ASSERT_CLK(a_amp_shrinks, clk, rst_n, valid_reg[6] |-> amp7_reg <= carry_reg[6].amp)
    `ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> valid_reg == '0)

endmodule

[src/perlin_noise_3d_octave_sum.sv]
// Top level: configuration registers, octave cell chain and saturating output register.
//
// Streams voxel coordinates in and fractal gradient-noise values out.
// Input channel: coord_valid/coord_stall with coord_x, coord_y, coord_z.
// Output channel: noise_valid/noise_stall with noise_value (signed Q8.16).
// A transaction completes at a rising edge with valid high and stall low.
// One transaction per cycle is taken while the output is not held back.
// The path runs through one scaling stage, the octave cells in order and one output
// register; every octave has its own cell.
// Octaves at or above octave_count pass the running sum through unchanged.
// When the receiver stalls a waiting result, the whole chain holds and
// coord_stall rises; nothing is dropped. Reset empties the chain and loads
// the register defaults; no clearing pass is needed.
// Registers (APB, 32-bit, byte address 4*i): base_frequency, start_amplitude,
// persistence, octave_count. Write them only while the chain is empty.
`timescale 1ns / 1ps
module perlin_noise_3d_octave_sum
    import pnos_pkg::*;
#(
    parameter int COORD_BITS  = DEFAULT_COORD_BITS,
    parameter int MAX_OCTAVES = DEFAULT_MAX_OCTAVES
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [3:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      coord_valid,
    output logic                      coord_stall,
    input  logic [COORD_BITS-1:0]     coord_x,
    input  logic [COORD_BITS-1:0]     coord_y,
    input  logic [COORD_BITS-1:0]     coord_z,
    output logic                      noise_valid,
    input  logic                      noise_stall,
    output logic signed [NOISE_W-1:0] noise_value
);

    pnos_cfg_t cfg_reg;
    pnos_reg_e reg_sel;
    logic      wr_en;
    logic      advance;

    assign pready  = 1'b1;
    assign reg_sel = pnos_reg_e'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_frequency  <= RST_BASE_FREQ;
            cfg_reg.start_amplitude <= RST_START_AMP;
            cfg_reg.persistence     <= RST_PERSIST;
            cfg_reg.octave_count    <= RST_OCT_COUNT;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_BASE_FREQ: cfg_reg.base_frequency  <= pwdata[FREQ_W-1:0];
                REG_START_AMP: cfg_reg.start_amplitude <= pwdata[AMP_W-1:0];
                REG_PERSIST:   cfg_reg.persistence     <= pwdata[PERS_W-1:0];
                REG_OCT_COUNT: cfg_reg.octave_count    <= pwdata[CNT_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_BASE_FREQ: prdata = 32'(cfg_reg.base_frequency);
            REG_START_AMP: prdata = 32'(cfg_reg.start_amplitude);
            REG_PERSIST:   prdata = 32'(cfg_reg.persistence);
            REG_OCT_COUNT: prdata = 32'(cfg_reg.octave_count);
            default:       prdata = '0;
        endcase
    end

    logic noise_valid_reg;
    logic signed [NOISE_W-1:0] noise_value_reg;

    // the chain moves unless a finished result is held by the receiver
    assign advance     = !(noise_valid_reg && noise_stall);
    assign coord_stall = !advance;

    logic        chain_valid [MAX_OCTAVES+1];
    pnos_carry_t chain_carry [MAX_OCTAVES+1];

    pnos_scale #(
        .COORD_BITS (COORD_BITS)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .cfg       (cfg_reg),
        .in_valid  (coord_valid),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .coord_z   (coord_z),
        .out_valid (chain_valid[0]),
        .out_carry (chain_carry[0])
    );

    for (genvar o = 0; o < MAX_OCTAVES; o++)
    begin : g_oct
        pnos_cell #(
            .OCT_INDEX (o)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .cfg       (cfg_reg),
            .in_valid  (chain_valid[o]),
            .in_carry  (chain_carry[o]),
            .out_valid (chain_valid[o+1]),
            .out_carry (chain_carry[o+1])
        );
    end

    logic signed [SUM_W-1:0]   total;
    logic signed [NOISE_W-1:0] sat_value;

    always_comb
    begin
        total = chain_carry[MAX_OCTAVES].sum;
        if (total > OUT_MAX)
            sat_value = NOISE_W'(OUT_MAX);
        else if (total < OUT_MIN)
            sat_value = NOISE_W'(OUT_MIN);
        else
            sat_value = NOISE_W'(total);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            noise_valid_reg <= 1'b0;
        else if (advance)
            noise_valid_reg <= chain_valid[MAX_OCTAVES];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            noise_value_reg <= sat_value;
    end

    assign noise_valid = noise_valid_reg;
    assign noise_value = noise_value_reg;

endmodule
